### sv/sha1_pkg.sv
// Shared types, constants and helpers for the SHA-1 engine.
package sha1_pkg;

  localparam logic [6:0] ROUND_LAST    = 7'd79;
  localparam logic [2:0] LAST_WORD_IDX = 3'd4;
  localparam logic [7:0] PAD_BYTE      = 8'h80;

  localparam logic [31:0] K0 = 32'h5a827999;
  localparam logic [31:0] K1 = 32'h6ed9eba1;
  localparam logic [31:0] K2 = 32'h8f1bbcdc;
  localparam logic [31:0] K3 = 32'hca62c1d6;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } msg_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } dig_t;

  typedef enum logic [1:0] {
    BYTE_MSG  = 2'd0,
    BYTE_PAD  = 2'd1,
    BYTE_ZERO = 2'd2,
    BYTE_LEN  = 2'd3
  } byte_sel_t;

  typedef struct packed {
    logic      shift_byte;
    byte_sel_t byte_sel;
    logic      count_len;
    logic      round_load;
    logic      round_step;
    logic      chain_add;
    logic      clear;
    logic      out_load;
    logic [2:0] out_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic count_full;
    logic count_ge56;
    logic round_last;
  } dp_status_t;

  function automatic logic [31:0] iv_word(input logic [2:0] idx);
    logic [31:0] w;
    case (idx)
      3'd0:    w = 32'h67452301;
      3'd1:    w = 32'hefcdab89;
      3'd2:    w = 32'h98badcfe;
      3'd3:    w = 32'h10325476;
      3'd4:    w = 32'hc3d2e1f0;
      default: w = 32'h0;
    endcase
    return w;
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] r);
    logic [63:0] d;
    d = {x, x} << r;
    return d[63:32];
  endfunction

endpackage

### sv/sha1_datapath.sv
// Datapath: block shift register, message schedule, round registers, chaining value.
module sha1_datapath import sha1_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  msg_t       msg,
  input  dp_cmd_t    cmd,
  output dp_status_t status,
  output dig_t       dig
);

  logic [511:0] blk;
  logic [31:0]  chain [5];
  logic [31:0]  a, b, c, d, e;
  logic [6:0]   rnd;
  logic [5:0]   count;
  logic [63:0]  mbits;

  logic [7:0]   byte_in;
  logic [7:0]   len_byte;
  logic [31:0]  w0, wnew, f, k, temp, out_word;

  assign len_byte = mbits[{~count[2:0], 3'b000} +: 8];

  always_comb begin
    case (cmd.byte_sel)
      BYTE_MSG:  byte_in = msg.data_byte;
      BYTE_PAD:  byte_in = PAD_BYTE;
      BYTE_LEN:  byte_in = len_byte;
      default:   byte_in = 8'h00;
    endcase
  end

  assign w0   = blk[511:480];
  assign wnew = rotl(blk[95:64] ^ blk[255:224] ^ blk[447:416] ^ w0, 5'd1);

  always_comb begin
    if (rnd inside {[7'd0:7'd19]}) begin
      f = d ^ (b & (c ^ d));
      k = K0;
    end else if (rnd inside {[7'd20:7'd39]}) begin
      f = b ^ c ^ d;
      k = K1;
    end else if (rnd inside {[7'd40:7'd59]}) begin
      f = (b & c) | (d & (b | c));
      k = K2;
    end else begin
      f = b ^ c ^ d;
      k = K3;
    end
  end

  assign temp = rotl(a, 5'd5) + f + e + w0 + k;

  always_ff @(posedge clk) begin
    if (cmd.shift_byte) begin
      blk <= {blk[503:0], byte_in};
    end else if (cmd.round_step) begin
      blk <= {blk[479:0], wnew};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.round_load) begin
      a   <= chain[0];
      b   <= chain[1];
      c   <= chain[2];
      d   <= chain[3];
      e   <= chain[4];
      rnd <= '0;
    end else if (cmd.round_step) begin
      a   <= temp;
      b   <= a;
      c   <= rotl(b, 5'd30);
      d   <= c;
      e   <= d;
      rnd <= rnd + 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      for (int i = 0; i < 5; i++) begin
        chain[i] <= iv_word(3'(i));
      end
      count <= '0;
      mbits <= '0;
    end else begin
      if (cmd.chain_add) begin
        chain[0] <= chain[0] + a;
        chain[1] <= chain[1] + b;
        chain[2] <= chain[2] + c;
        chain[3] <= chain[3] + d;
        chain[4] <= chain[4] + e;
      end
      if (cmd.shift_byte) begin
        count <= count + 6'd1;
      end
      if (cmd.count_len) begin
        mbits <= mbits + 64'd8;
      end
    end
  end

  always_comb begin
    case (cmd.out_idx)
      3'd0:    out_word = chain[0];
      3'd1:    out_word = chain[1];
      3'd2:    out_word = chain[2];
      3'd3:    out_word = chain[3];
      3'd4:    out_word = chain[4];
      default: out_word = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      dig.digest_word <= out_word;
      dig.word_index  <= cmd.out_idx;
      dig.last_word   <= (cmd.out_idx == LAST_WORD_IDX);
    end
  end

  assign status.count_full = (count == 6'd63);
  assign status.count_ge56 = (count[5:3] == 3'b111);
  assign status.round_last = (rnd == ROUND_LAST);

endmodule

### sv/sha1_ctrl.sv
// Controller: input acceptance, padding sequence, round sequencing, digest output.
module sha1_ctrl import sha1_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       msg_valid,
  output logic       msg_stall,
  input  msg_t       msg,
  output logic       dig_valid,
  input  logic       dig_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_PAD   = 5'b00010,
    S_ROUND = 5'b00100,
    S_FIN   = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t     state, state_next;
  logic       first_pad, first_pad_next;
  logic       len_ok, len_ok_next;
  logic       pad_active, pad_active_next;
  logic       pend_end, pend_end_next;
  logic       final_blk, final_blk_next;
  logic [2:0] idx, idx_next;
  logic       dig_valid_next;

  assign msg_stall = (state != S_IDLE);

  always_comb begin
    cmd             = '0;
    state_next      = state;
    first_pad_next  = first_pad;
    len_ok_next     = len_ok;
    pad_active_next = pad_active;
    pend_end_next   = pend_end;
    final_blk_next  = final_blk;
    idx_next        = idx;
    dig_valid_next  = dig_valid && dig_stall;
    cmd.byte_sel    = BYTE_MSG;
    cmd.out_idx     = idx;

    case (state)
      S_IDLE: begin
        if (msg_valid) begin
          if (msg.byte_present) begin
            cmd.shift_byte = 1'b1;
            cmd.count_len  = 1'b1;
            if (status.count_full) begin
              cmd.round_load = 1'b1;
              pend_end_next  = msg.end_of_message;
              state_next     = S_ROUND;
            end else if (msg.end_of_message) begin
              first_pad_next  = 1'b1;
              pad_active_next = 1'b1;
              state_next      = S_PAD;
            end
          end else if (msg.end_of_message) begin
            first_pad_next  = 1'b1;
            pad_active_next = 1'b1;
            state_next      = S_PAD;
          end
        end
      end
      S_PAD: begin
        cmd.shift_byte = 1'b1;
        if (first_pad) begin
          cmd.byte_sel   = BYTE_PAD;
          len_ok_next    = !status.count_ge56;
          first_pad_next = 1'b0;
        end else if (len_ok && status.count_ge56) begin
          cmd.byte_sel = BYTE_LEN;
        end else begin
          cmd.byte_sel = BYTE_ZERO;
        end
        if (status.count_full) begin
          cmd.round_load = 1'b1;
          final_blk_next = !first_pad && len_ok;
          state_next     = S_ROUND;
        end
      end
      S_ROUND: begin
        cmd.round_step = 1'b1;
        if (status.round_last) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        cmd.chain_add = 1'b1;
        if (final_blk) begin
          idx_next   = '0;
          state_next = S_EMIT;
        end else if (pad_active) begin
          len_ok_next = 1'b1;
          state_next  = S_PAD;
        end else if (pend_end) begin
          first_pad_next  = 1'b1;
          pad_active_next = 1'b1;
          state_next      = S_PAD;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_EMIT: begin
        if (!dig_valid || !dig_stall) begin
          cmd.out_load   = 1'b1;
          dig_valid_next = 1'b1;
          if (idx == LAST_WORD_IDX) begin
            cmd.clear       = 1'b1;
            idx_next        = '0;
            pad_active_next = 1'b0;
            pend_end_next   = 1'b0;
            final_blk_next  = 1'b0;
            state_next      = S_IDLE;
          end else begin
            idx_next = idx + 3'd1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      first_pad  <= 1'b0;
      len_ok     <= 1'b0;
      pad_active <= 1'b0;
      pend_end   <= 1'b0;
      final_blk  <= 1'b0;
      idx        <= '0;
      dig_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      first_pad  <= first_pad_next;
      len_ok     <= len_ok_next;
      pad_active <= pad_active_next;
      pend_end   <= pend_end_next;
      final_blk  <= final_blk_next;
      idx        <= idx_next;
      dig_valid  <= dig_valid_next;
    end
  end

  a_no_shift_in_round: assert property (@(posedge clk) disable iff (rst)
    !(cmd.shift_byte && cmd.round_step))
    else $error("byte shift during compression round");

  a_rounds_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUND && status.round_last) |=> (state == S_FIN))
    else $error("round sequence did not finish");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (dig_valid && dig_stall) |-> !cmd.out_load)
    else $error("digest word overwritten while stalled");

  a_clear_on_last: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |-> (cmd.out_load && cmd.out_idx == LAST_WORD_IDX))
    else $error("chain cleared before last word loaded");

endmodule

### sv/sha1_hash_engine.sv
// SHA-1 engine top level: controller and datapath.
// Message bytes are taken one per cycle while msg_stall is low; a full 64-byte block then
// stalls input for 80 rounds, one per cycle in the round datapath, plus the chaining add.
// End of message: padding shifts one byte per cycle to the block end; each padded block
// is compressed, then five digest words go out, one per cycle unless dig_stall holds them.
// Reset is synchronous: chaining value to the initial words, counters and control cleared.
module sha1_hash_engine import sha1_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic msg_valid,
  output logic msg_stall,
  input  msg_t msg,
  output logic dig_valid,
  input  logic dig_stall,
  output dig_t dig
);

  dp_cmd_t    cmd;
  dp_status_t status;

  sha1_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .msg_valid (msg_valid),
    .msg_stall (msg_stall),
    .msg       (msg),
    .dig_valid (dig_valid),
    .dig_stall (dig_stall),
    .status    (status),
    .cmd       (cmd)
  );

  sha1_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .msg    (msg),
    .cmd    (cmd),
    .status (status),
    .dig    (dig)
  );

endmodule
